/* src/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the script token lexer
// Holds the beat types of both channels, the queue entry between the front and
// the back of the lexer, the character classes and the token kinds.
// ----------------------------------------------------------------------------
package stl_pkg;

   // Default width of the source byte offset counter.
   localparam int OFFSET_BITS_DEFAULT = 16;
   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Width of the reported start offset and token length.
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] LEN_MAX = '1;

   // Character classes found by the front.
   localparam logic [2:0] CLS_SPACE  = 3'd0;
   localparam logic [2:0] CLS_LETTER = 3'd1;
   localparam logic [2:0] CLS_DIGIT  = 3'd2;
   localparam logic [2:0] CLS_UNDER  = 3'd3;
   localparam logic [2:0] CLS_DOT    = 3'd4;
   localparam logic [2:0] CLS_QUOTE  = 3'd5;
   localparam logic [2:0] CLS_PUNCT  = 3'd6;
   localparam logic [2:0] CLS_OTHER  = 3'd7;

   // Token kinds as reported on the result channel.
   localparam logic [1:0] KIND_IDENT  = 2'd0;
   localparam logic [1:0] KIND_NUMBER = 2'd1;
   localparam logic [1:0] KIND_STRING = 2'd2;
   localparam logic [1:0] KIND_OPER   = 2'd3;

   // Source characters with a role of their own.
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [1:0]          token_kind;
      logic [POS_BITS-1:0] token_start;
      logic [POS_BITS-1:0] token_length;
      logic                last_of_run;
      logic                last_of_source;
   } rsp_type;

   // One classified byte on its way from the front to the back.
   typedef struct packed {
      logic [2:0]          char_class;
      logic [POS_BITS-1:0] pos;
      logic                last;
   } entry_type;

endpackage

/* src/stl_front.sv */
// ----------------------------------------------------------------------------
// stl_front: byte classifier and offset counter
// Sorts each accepted byte into a character class and tags it with its offset
// within the current source text.
// ----------------------------------------------------------------------------
module stl_front #(
   parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stl_pkg::req_type    req_data,
   output stl_pkg::entry_type  entry
);

   logic [OFFSET_BITS-1:0]       offset_ff;
   logic [OFFSET_BITS-1:0]       offset_in;
   logic [stl_pkg::POS_BITS-1:0] pos_tok;
   logic [2:0]                   char_class;
   logic [7:0]                   c;

   assign c = req_data.char_code;

   // The reported offset is the low bits of the counter, zero padded when
   // the counter is narrower.
   if (OFFSET_BITS >= stl_pkg::POS_BITS) begin : g_pos_cut
      assign pos_tok = offset_ff[stl_pkg::POS_BITS-1:0];
   end else begin : g_pos_pad
      assign pos_tok = {{(stl_pkg::POS_BITS-OFFSET_BITS){1'b0}}, offset_ff};
   end

   always_comb begin
      if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
         char_class = stl_pkg::CLS_SPACE;
      end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
         char_class = stl_pkg::CLS_LETTER;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         char_class = stl_pkg::CLS_DIGIT;
      end else if (c == stl_pkg::CHAR_UNDER) begin
         char_class = stl_pkg::CLS_UNDER;
      end else if (c == stl_pkg::CHAR_DOT) begin
         char_class = stl_pkg::CLS_DOT;
      end else if (c == stl_pkg::CHAR_QUOTE) begin
         char_class = stl_pkg::CLS_QUOTE;
      end else if (c == stl_pkg::CHAR_SEMI || c == stl_pkg::CHAR_LPAREN ||
                   c == stl_pkg::CHAR_RPAREN) begin
         char_class = stl_pkg::CLS_PUNCT;
      end else begin
         char_class = stl_pkg::CLS_OTHER;
      end
   end

   assign entry.char_class = char_class;
   assign entry.pos        = pos_tok;
   assign entry.last       = req_data.end_of_source;

   // The offset restarts at zero after the last byte of a source.
   always_comb begin
      offset_in = offset_ff;
      if (push) begin
         if (req_data.end_of_source) begin
            offset_in = '0;
         end else begin
            offset_in = offset_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

/* src/stl_queue.sv */
// ----------------------------------------------------------------------------
// stl_queue: short first-in first-out queue of classified bytes
// Decouples the front from the back so that each side can stall on its own.
// ----------------------------------------------------------------------------
module stl_queue #(
   parameter int DEPTH = stl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stl_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output stl_pkg::entry_type head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   stl_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/stl_back.sv */
// ----------------------------------------------------------------------------
// stl_back: token state machine and result buffer
// Takes classified bytes from the queue, tracks the open token and writes up
// to two token descriptors per byte into a two-beat result buffer.
// ----------------------------------------------------------------------------
module stl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  stl_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stl_pkg::rsp_type   rsp_data
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_IDENT  = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_OPER   = 3'd4;

   localparam int PB = stl_pkg::POS_BITS;

   logic [2:0]      mode_ff, mode_in;
   logic [PB-1:0]   start_ff, start_in;
   logic [PB-1:0]   len_ff, len_in;
   logic [2:0]      mode_n;
   logic [PB-1:0]   start_n, len_n, len_g;
   stl_pkg::rsp_type res [2];
   logic [1:0]      n;
   logic            do_open;
   logic [2:0]      cls;

   stl_pkg::rsp_type slot_ff [2];
   stl_pkg::rsp_type slot_in [2];
   stl_pkg::rsp_type keep [2];
   logic [1:0]      cnt_ff, cnt_in;
   logic            out_pop;
   logic [1:0]      base;
   logic [1:0]      rel;

   function automatic stl_pkg::rsp_type make_rsp(input logic [1:0] kind,
                                                 input logic [PB-1:0] start,
                                                 input logic [PB-1:0] len);
      stl_pkg::rsp_type r;
      r.token_kind     = kind;
      r.token_start    = start;
      r.token_length   = len;
      r.last_of_run    = 1'b0;
      r.last_of_source = 1'b0;
      return r;
   endfunction

   function automatic logic [1:0] mode_kind(input logic [2:0] m);
      logic [1:0] k;
      unique case (m)
         MODE_IDENT:  k = stl_pkg::KIND_IDENT;
         MODE_NUMBER: k = stl_pkg::KIND_NUMBER;
         MODE_STRING: k = stl_pkg::KIND_STRING;
         default:     k = stl_pkg::KIND_OPER;
      endcase
      return k;
   endfunction

   assign cls   = q_head.char_class;
   assign len_g = (len_ff == stl_pkg::LEN_MAX) ? len_ff : len_ff + 1'b1;

   // Token decisions for the byte at the head of the queue.
   always_comb begin
      mode_n  = mode_ff;
      start_n = start_ff;
      len_n   = len_ff;
      n       = 2'd0;
      do_open = 1'b0;
      res[0]  = make_rsp(stl_pkg::KIND_IDENT, '0, '0);
      res[1]  = make_rsp(stl_pkg::KIND_IDENT, '0, '0);

      unique case (mode_ff)
         MODE_STRING: begin
            len_n = len_g;
            if (cls == stl_pkg::CLS_QUOTE) begin
               res[n[0]] = make_rsp(stl_pkg::KIND_STRING, start_ff, len_g);
               n         = n + 2'd1;
               mode_n    = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (cls inside {stl_pkg::CLS_LETTER, stl_pkg::CLS_DIGIT, stl_pkg::CLS_UNDER}) begin
               len_n = len_g;
            end else begin
               res[n[0]] = make_rsp(stl_pkg::KIND_IDENT, start_ff, len_ff);
               n         = n + 2'd1;
               do_open   = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (cls inside {stl_pkg::CLS_DIGIT, stl_pkg::CLS_DOT}) begin
               len_n = len_g;
            end else begin
               res[n[0]] = make_rsp(stl_pkg::KIND_NUMBER, start_ff, len_ff);
               n         = n + 2'd1;
               do_open   = 1'b1;
            end
         end
         MODE_OPER: begin
            if (!(cls inside {stl_pkg::CLS_SPACE, stl_pkg::CLS_LETTER, stl_pkg::CLS_DIGIT})) begin
               len_n = len_g;
            end else begin
               res[n[0]] = make_rsp(stl_pkg::KIND_OPER, start_ff, len_ff);
               n         = n + 2'd1;
               do_open   = 1'b1;
            end
         end
         default: begin
            do_open = 1'b1;
         end
      endcase

      if (do_open) begin
         mode_n = MODE_IDLE;
         unique case (cls)
            stl_pkg::CLS_SPACE: begin
            end
            stl_pkg::CLS_PUNCT: begin
               res[n[0]] = make_rsp(stl_pkg::KIND_OPER, q_head.pos, PB'(1));
               n         = n + 2'd1;
            end
            stl_pkg::CLS_QUOTE: begin
               mode_n  = MODE_STRING;
               start_n = q_head.pos;
               len_n   = PB'(1);
            end
            stl_pkg::CLS_LETTER: begin
               mode_n  = MODE_IDENT;
               start_n = q_head.pos;
               len_n   = PB'(1);
            end
            stl_pkg::CLS_DIGIT: begin
               mode_n  = MODE_NUMBER;
               start_n = q_head.pos;
               len_n   = PB'(1);
            end
            default: begin
               mode_n  = MODE_OPER;
               start_n = q_head.pos;
               len_n   = PB'(1);
            end
         endcase
      end

      // The end of the source closes whatever token is still open.
      if (q_head.last) begin
         if (mode_n != MODE_IDLE) begin
            res[n[0]] = make_rsp(mode_kind(mode_n), start_n, len_n);
            n         = n + 2'd1;
         end
         mode_n = MODE_IDLE;
         len_n  = '0;
      end

      if (n != 2'd0) begin
         res[n[1]].last_of_run    = 1'b1;
         res[n[1]].last_of_source = q_head.last;
      end
   end

   // Result buffer: two beats, drained from the front slot.
   assign out_pop   = (cnt_ff != 2'd0) && !rsp_stall;
   assign base      = cnt_ff - {1'b0, out_pop};
   assign q_pop     = q_valid && (({1'b0, base} + {1'b0, n}) <= 3'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[0];

   always_comb begin
      keep[0] = out_pop ? slot_ff[1] : slot_ff[0];
      keep[1] = slot_ff[1];
      cnt_in  = base + (q_pop ? n : 2'd0);
      for (int i = 0; i < 2; i++) begin
         rel        = 2'(i) - base;
         slot_in[i] = keep[i];
         if (q_pop && (2'(i) >= base) && (rel < n)) begin
            slot_in[i] = res[rel[0]];
         end
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      if (q_pop) begin
         mode_in  = mode_n;
         start_in = start_n;
         len_in   = len_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

/* src/script_token_lexer.sv */
// ----------------------------------------------------------------------------
// script_token_lexer: streaming tokenizer for script source text
// Takes source text one byte per beat and returns token descriptors (kind,
// start offset, length) on the byte that closes each token.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                           Beat contents
//   -------   -----------------------------   --------------------------------
//   request   req_valid, req_stall, req_data  char_code, end_of_source
//   response  rsp_valid, rsp_stall, rsp_data  token_kind, token_start,
//                                             token_length, last_of_run,
//                                             last_of_source
//
// One byte is taken per cycle while the queue has room. A byte passes through
// the queue and then the result buffer before it reaches the response port.
// The response side moves at most one beat per cycle, so a byte that produces
// two tokens takes two response beats, and a steady run of such bytes is
// taken at a lower byte rate. Reset is synchronous and clears the queue, the
// token state and the offset counter; no clearing pass is needed. A stall on
// the response side fills the result buffer and then the queue, and only
// then raises req_stall.
//
// The front classifies each byte and tags it with its offset in the source.
// The back holds the open token (mode, start, length) and decides, byte by
// byte, whether the token grows, closes, or closes and is followed by a new
// one. Offsets wrap at 2^OFFSET_BITS and lengths saturate at 65535.
// ----------------------------------------------------------------------------
module script_token_lexer #(
   parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stl_pkg::rsp_type rsp_data
);

   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic               push;
   stl_pkg::entry_type entry;
   stl_pkg::entry_type q_head;

   // A byte is taken whenever the queue has room.
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   stl_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .entry    (entry)
   );

   stl_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   stl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for script_token_lexer
// Feeds source bytes over the request channel and predicts every token
// descriptor. The response channel is checked beat by beat against the
// predicted tokens while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   // A byte passes through the queue and then the result buffer before it reaches
   // the response port; the drain keeps watching after the last expected beat.
   localparam int DRAIN_CYCLES = 24;
   // The limit is set well above the slowest correct run.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 900;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   stl_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   stl_pkg::rsp_type rsp_data;

   script_token_lexer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   int unsigned fail_count = 0;
   int unsigned beats_sent = 0;
   int unsigned cycle_count = 0;

   // ------------------------------------------------------------------------
   // Token predictor. It tracks the open token exactly as the lexer must:
   // the mode, the start offset, the saturating length and the offset of the
   // next byte within the current source.
   // ------------------------------------------------------------------------
   typedef enum logic [2:0] {
      ST_IDLE, ST_IDENT, ST_NUMBER, ST_STRING, ST_OPER
   } lex_state_type;

   lex_state_type                lex_state  = ST_IDLE;
   logic [stl_pkg::POS_BITS-1:0] tok_start  = '0;
   logic [stl_pkg::POS_BITS-1:0] tok_len    = '0;
   logic [stl_pkg::POS_BITS-1:0] src_offset = '0;

   stl_pkg::rsp_type beat_tokens [2];
   int               beat_count;
   stl_pkg::rsp_type expected_tokens [$];

   function automatic bit char_is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit char_is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit char_is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit char_is_alnum(logic [7:0] c);
      return char_is_letter(c) || char_is_digit(c);
   endfunction

   function automatic bit char_is_punct(logic [7:0] c);
      return c == stl_pkg::CHAR_SEMI || c == stl_pkg::CHAR_LPAREN ||
             c == stl_pkg::CHAR_RPAREN;
   endfunction

   function automatic logic [1:0] state_kind(lex_state_type st);
      case (st)
         ST_IDENT:  return stl_pkg::KIND_IDENT;
         ST_NUMBER: return stl_pkg::KIND_NUMBER;
         ST_STRING: return stl_pkg::KIND_STRING;
         default:   return stl_pkg::KIND_OPER;
      endcase
   endfunction

   function automatic void emit_token(logic [1:0] kind,
                                      logic [stl_pkg::POS_BITS-1:0] start,
                                      logic [stl_pkg::POS_BITS-1:0] len);
      stl_pkg::rsp_type t;
      t              = '0;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      beat_tokens[beat_count] = t;
      beat_count++;
   endfunction

   function automatic void close_token();
      emit_token(state_kind(lex_state), tok_start, tok_len);
      lex_state = ST_IDLE;
   endfunction

   function automatic void grow_token();
      if (tok_len != stl_pkg::LEN_MAX) tok_len++;
   endfunction

   // Starts whatever the byte opens. Punctuation closes itself at once.
   function automatic void open_token(logic [7:0] c, logic [stl_pkg::POS_BITS-1:0] pos);
      lex_state = ST_IDLE;
      if (char_is_space(c)) return;
      if (char_is_punct(c)) begin
         emit_token(stl_pkg::KIND_OPER, pos, 16'd1);
         return;
      end
      tok_start = pos;
      tok_len   = 16'd1;
      if (c == stl_pkg::CHAR_QUOTE) lex_state = ST_STRING;
      else if (char_is_letter(c)) lex_state = ST_IDENT;
      else if (char_is_digit(c)) lex_state = ST_NUMBER;
      else lex_state = ST_OPER;
   endfunction

   function automatic void predict_tokens(stl_pkg::req_type beat);
      logic [7:0]                   c;
      logic [stl_pkg::POS_BITS-1:0] pos;
      c          = beat.char_code;
      pos        = src_offset;
      beat_count = 0;
      case (lex_state)
         ST_STRING: begin
            grow_token();
            if (c == stl_pkg::CHAR_QUOTE) close_token();
         end
         ST_IDENT: begin
            if (char_is_alnum(c) || c == stl_pkg::CHAR_UNDER) grow_token();
            else begin
               close_token();
               open_token(c, pos);
            end
         end
         ST_NUMBER: begin
            if (char_is_digit(c) || c == stl_pkg::CHAR_DOT) grow_token();
            else begin
               close_token();
               open_token(c, pos);
            end
         end
         ST_OPER: begin
            // Punctuation inside an operator run simply extends the run.
            if (!char_is_space(c) && !char_is_alnum(c)) grow_token();
            else begin
               close_token();
               open_token(c, pos);
            end
         end
         default: open_token(c, pos);
      endcase

      // The end byte closes any open token and rewinds the offset, so the
      // next byte starts a fresh source. Trailing whitespace yields nothing.
      if (beat.end_of_source) begin
         if (lex_state != ST_IDLE) close_token();
         lex_state  = ST_IDLE;
         tok_len    = '0;
         src_offset = '0;
         if (beat_count > 0) beat_tokens[beat_count-1].last_of_source = 1'b1;
      end else begin
         src_offset = pos + 1'b1;
      end

      if (beat_count > 0) beat_tokens[beat_count-1].last_of_run = 1'b1;
      for (int i = 0; i < beat_count; i++)
         expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Each byte waits a random idle gap before it is offered.
   // Valid is only lowered when a gap follows, so a back-to-back byte never
   // sees valid dropped and raised within one step.
   // ------------------------------------------------------------------------
   task automatic send_beat(logic [7:0] c, logic last);
      stl_pkg::req_type beat;
      int               gap;
      beat.char_code     = c;
      beat.end_of_source = last;
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_tokens(beat);
      beats_sent++;
   endtask

   task automatic send_text(string s, bit mark_end);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], mark_end && i == s.len() - 1);
   endtask

   // ------------------------------------------------------------------------
   // Response side. Before each beat the receiver stalls for a random gap,
   // then holds stall low until a beat is taken.
   // ------------------------------------------------------------------------
   initial begin : rsp_pacing
      int n;
      forever begin
         n = $urandom_range(0, 11);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Every accepted response beat is compared with the oldest prediction.
   always @(posedge clock) begin
      stl_pkg::rsp_type exp_tok;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $error("token beat with nothing expected: kind %0d start %0d length %0d",
                   rsp_data.token_kind, rsp_data.token_start, rsp_data.token_length);
            fail_count++;
         end else begin
            exp_tok = expected_tokens.pop_front();
            if (rsp_data.token_kind !== exp_tok.token_kind) begin
               $error("token_kind: expected %0d, got %0d",
                      exp_tok.token_kind, rsp_data.token_kind);
               fail_count++;
            end
            if (rsp_data.token_start !== exp_tok.token_start) begin
               $error("token_start: expected %0d, got %0d",
                      exp_tok.token_start, rsp_data.token_start);
               fail_count++;
            end
            if (rsp_data.token_length !== exp_tok.token_length) begin
               $error("token_length: expected %0d, got %0d",
                      exp_tok.token_length, rsp_data.token_length);
               fail_count++;
            end
            if (rsp_data.last_of_run !== exp_tok.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      exp_tok.last_of_run, rsp_data.last_of_run);
               fail_count++;
            end
            if (rsp_data.last_of_source !== exp_tok.last_of_source) begin
               $error("last_of_source: expected %0d, got %0d",
                      exp_tok.last_of_source, rsp_data.last_of_source);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every token kind, punctuation right after a token (two results from one
   // byte), punctuation inside an operator run, the byte extremes, an
   // unclosed string ended by the end byte and trailing whitespace.
   task automatic test_token_kinds();
      send_text("ab_9;", 1'b0);
      send_text(" 3.1)", 1'b0);
      send_text("\"x \"", 1'b0);
      send_text("+;(", 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text(" \"q", 1'b1);
      send_text("k;", 1'b1);
      send_text("z\t", 1'b1);
   endtask

   // Tokens long enough to carry the length and the start offset well past
   // eight bits, with an operator run closed by the end byte.
   task automatic test_long_tokens();
      repeat (300) send_beat("a", 1'b0);
      send_text(" ab ", 1'b0);
      repeat (200) send_beat("-", 1'b0);
      send_beat(stl_pkg::CHAR_SEMI, 1'b1);
   endtask

   function automatic logic [7:0] pick_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                  : 8'($urandom_range("A", "Z"));
   endfunction

   function automatic logic [7:0] pick_oper_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (char_is_space(c) || char_is_alnum(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_space();
      return $urandom_range(0, 5) == 0 ? 8'd32 : 8'($urandom_range(9, 13));
   endfunction

   // Mostly well-formed token streams with random content; some bytes are
   // pure noise, tokens are often glued together and strings sometimes never
   // close.
   task automatic test_random_sources();
      logic [7:0] src [$];
      int         n_tok;
      int         len;
      logic [7:0] c;
      while (beats_sent < RANDOM_BEATS) begin
         src.delete();
         n_tok = $urandom_range(1, 10);
         for (int t = 0; t < n_tok; t++) begin
            case ($urandom_range(0, 7))
               0: begin
                  src.insert(src.size(), pick_letter());
                  len = $urandom_range(0, 6);
                  for (int i = 0; i < len; i++) begin
                     case ($urandom_range(0, 2))
                        0: c = pick_letter();
                        1: c = 8'($urandom_range("0", "9"));
                        default: c = stl_pkg::CHAR_UNDER;
                     endcase
                     src.insert(src.size(), c);
                  end
               end
               1: begin
                  src.insert(src.size(), 8'($urandom_range("0", "9")));
                  len = $urandom_range(0, 5);
                  for (int i = 0; i < len; i++)
                     src.insert(src.size(), $urandom_range(0, 3) == 0
                                            ? stl_pkg::CHAR_DOT
                                            : 8'($urandom_range("0", "9")));
               end
               2: begin
                  src.insert(src.size(), stl_pkg::CHAR_QUOTE);
                  len = $urandom_range(0, 6);
                  for (int i = 0; i < len; i++) begin
                     do c = 8'($urandom_range(0, 255)); while (c == stl_pkg::CHAR_QUOTE);
                     src.insert(src.size(), c);
                  end
                  if ($urandom_range(0, 7) != 0) src.insert(src.size(), stl_pkg::CHAR_QUOTE);
               end
               3: begin
                  len = $urandom_range(1, 4);
                  for (int i = 0; i < len; i++) src.insert(src.size(), pick_oper_char());
               end
               4: begin
                  case ($urandom_range(0, 2))
                     0: src.insert(src.size(), stl_pkg::CHAR_SEMI);
                     1: src.insert(src.size(), stl_pkg::CHAR_LPAREN);
                     default: src.insert(src.size(), stl_pkg::CHAR_RPAREN);
                  endcase
               end
               5: begin
                  len = $urandom_range(1, 3);
                  for (int i = 0; i < len; i++) src.insert(src.size(), pick_space());
               end
               default: begin
                  len = $urandom_range(1, 2);
                  for (int i = 0; i < len; i++)
                     src.insert(src.size(), 8'($urandom_range(0, 255)));
               end
            endcase
            if ($urandom_range(0, 1)) src.insert(src.size(), pick_space());
         end
         foreach (src[i]) send_beat(src[i], i == src.size() - 1);
      end
   endtask

   // Lets every predicted token arrive, then watches a while longer for any
   // beat that should not be there.
   task automatic drain_tokens();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_token_kinds();
      test_long_tokens();
      test_random_sources();
      drain_tokens();

      if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
